/* design/hbm_pkg.sv */
package hbm_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_RESET  = 4096;
  localparam int MIN_SIZE   = 4;
  localparam int PROBE_SLACK = 3;
  localparam int FIRST_SLOT = 1;
  localparam int WORD_W     = 32;
  localparam int IDX_OUT_W  = 12;

  // remainder unit: bits of the hash consumed per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = WORD_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_SKIP   = 3'd0,
    ST_NEW    = 3'd1,
    ST_MERGED = 3'd2,
    ST_FULL   = 3'd3,
    ST_HALTED = 3'd4
  } status_e;

  typedef struct packed {
    logic [WORD_W-1:0] bucket_hash;
    logic [WORD_W-1:0] bucket_key;
    logic [WORD_W-1:0] bucket_count;
  } bucket_in_t;

  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [WORD_W-1:0]    new_count;
  } bucket_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] count;
  } slot_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE,
    B_RESULT
  } back_state_e;

endpackage

/* design/hbm_front.sv */
module hbm_front import hbm_pkg::*; #(
  parameter int TableDepth = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 busy_i,
  input  logic [$clog2(TableDepth+1)-1:0]      size_i,
  input  logic                                 push,
  output logic                                 full,
  input  bucket_in_t                           bucket_i,
  output logic                                 q_push_o,
  input  logic                                 q_full_i,
  output bucket_in_t                           item_o,
  output logic [$clog2(TableDepth)-1:0]        home_o
);

  localparam int SizeW = $clog2(TableDepth + 1);
  localparam int SlotW = $clog2(TableDepth);

  front_state_e         state_q, state_d;
  bucket_in_t           item_q, item_d;
  logic [WORD_W-1:0]    shf_q, shf_d;
  logic [SizeW-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic [SizeW:0]       r;

  // restoring remainder, a few hash bits per cycle
  always_comb begin
    r = {1'b0, rem_q};
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[SizeW-1:0], shf_q[WORD_W-1-i]};
      if (r >= {1'b0, size_i}) begin
        r = r - {1'b0, size_i};
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    shf_d    = shf_q;
    rem_d    = rem_q;
    step_d   = step_q;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push && !busy_i) begin
          item_d = bucket_i;
          shf_d  = bucket_i.bucket_hash;
          rem_d  = '0;
          step_d = '0;
          // empty buckets need no home slot
          state_d = (bucket_i.bucket_count == '0) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = r[SizeW-1:0];
        shf_d  = shf_q << DIV_BITS;
        step_d = step_q + 1'b1;
        if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    shf_q  <= shf_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  assign full   = (state_q != F_IDLE) || busy_i;
  assign item_o = item_q;
  assign home_o = (rem_q == '0) ? SlotW'(FIRST_SLOT) : SlotW'(rem_q);

endmodule

/* design/hbm_queue.sv */
module hbm_queue #(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);

  logic [DataW-1:0] buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = buf_q[rd_ptr_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == '0);

endmodule

/* design/hbm_back.sv */
module hbm_back import hbm_pkg::*; #(
  parameter int TableDepth = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(TableDepth+1)-1:0] size_i,
  output logic                            busy_o,
  input  logic                            q_empty_i,
  output logic                            q_pop_o,
  input  bucket_in_t                      item_i,
  input  logic [$clog2(TableDepth)-1:0]   home_i,
  output logic                            empty,
  input  logic                            pop,
  output bucket_out_t                     result_o
);

  localparam int SizeW = $clog2(TableDepth + 1);
  localparam int SlotW = $clog2(TableDepth);

  slot_t             mem [TableDepth];
  slot_t             rdata_q;
  logic              mem_we;
  logic [SlotW-1:0]  mem_waddr, mem_raddr;
  slot_t             mem_wdata;

  back_state_e       state_q, state_d;
  logic [SlotW-1:0]  clr_q, clr_d;
  logic              halted_q, halted_d;
  bucket_in_t        item_q, item_d;
  logic [SlotW-1:0]  idx_q, idx_d, idx_next;
  logic [SizeW-1:0]  moves_q, moves_d, idx_inc;
  bucket_out_t       res_q, res_d;
  bucket_out_t       out_q;
  logic              out_valid_q, out_load;
  logic              hit_empty, hit_match;
  logic [WORD_W-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign hit_empty = (rdata_q.hash == '0);
  assign hit_match = (rdata_q.hash == item_q.bucket_hash) &&
                     (rdata_q.key == item_q.bucket_key);
  assign sum       = rdata_q.count + item_q.bucket_count;
  assign idx_inc   = SizeW'(idx_q) + SizeW'(1);
  // linear walk over slots 1..size-1, slot 0 skipped on wrap
  assign idx_next  = (idx_inc >= size_i) ? SlotW'(FIRST_SLOT) : idx_inc[SlotW-1:0];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    halted_d  = halted_q;
    item_d    = item_q;
    idx_d     = idx_q;
    moves_d   = moves_q;
    res_d     = res_q;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_raddr = idx_q;
    case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == SlotW'(TableDepth - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = item_i;
          idx_d   = home_i;
          moves_d = '0;
          mem_raddr = home_i;
          if (halted_q) begin
            res_d   = '{status: ST_HALTED, slot_index: '0, new_count: '0};
            state_d = B_RESULT;
          end else if (item_i.bucket_count == '0) begin
            res_d   = '{status: ST_SKIP, slot_index: '0, new_count: '0};
            state_d = B_RESULT;
          end else begin
            state_d = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        if (hit_empty || hit_match) begin
          mem_we    = 1'b1;
          mem_wdata = '{hash: item_q.bucket_hash, key: item_q.bucket_key, count: sum};
          res_d     = '{status: hit_empty ? ST_NEW : ST_MERGED,
                        slot_index: IDX_OUT_W'(idx_q), new_count: sum};
          state_d   = B_RESULT;
        end else if (moves_q >= size_i - SizeW'(PROBE_SLACK)) begin
          halted_d = 1'b1;
          res_d    = '{status: ST_FULL, slot_index: '0, new_count: '0};
          state_d  = B_RESULT;
        end else begin
          idx_d     = idx_next;
          moves_d   = moves_q + 1'b1;
          mem_raddr = idx_next;
        end
      end
      B_RESULT: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      halted_q <= halted_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    idx_q   <= idx_d;
    moves_q <= moves_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign busy_o   = (state_q == B_CLEAR);
  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

/* design/hash_bucket_merge_linear_probe.sv */
// Merges source buckets (hash, key, count) into a linear-probing table, one result word per
// input word, in order. The front stage computes the home slot with a remainder unit that
// takes 4 hash bits per cycle, so a word with nonzero count holds the input through accept,
// 8 remainder steps and hand-off, and a zero-count word through accept and hand-off only.
// The back stage pops a word and walks the probes with one table read per cycle through the
// registered read port of the slot memory; through the two-entry queue the front stage can
// accept the next word while the back stage still probes. After reset the back stage clears
// the table, one slot per cycle, and full stays high until that pass ends. table_size is
// clamped to 4..TableDepth and may only be written while the block is idle.
module hash_bucket_merge_linear_probe import hbm_pkg::*; #(
  parameter int TableDepth = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  bucket_in_t       bucket_i,
  output logic             empty,
  input  logic             pop,
  output bucket_out_t      result_o
);

  localparam int SizeW     = $clog2(TableDepth + 1);
  localparam int SlotW     = $clog2(TableDepth);
  localparam int ResetSize = (CFG_RESET > TableDepth) ? TableDepth : CFG_RESET;
  localparam int QDataW    = $bits(bucket_in_t) + SlotW;

  logic [SizeW-1:0]  size_q;
  logic              clearing;
  logic              q_push, q_full, q_pop, q_empty;
  bucket_in_t        f_item, b_item;
  logic [SlotW-1:0]  f_home, b_home;
  logic [QDataW-1:0] q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(ResetSize);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < CFG_W'(MIN_SIZE)) begin
        size_q <= SizeW'(MIN_SIZE);
      end else if (int'(cfg_wdata_i) > TableDepth) begin
        size_q <= SizeW'(TableDepth);
      end else begin
        size_q <= SizeW'(cfg_wdata_i);
      end
    end
  end

  hbm_front #(
    .TableDepth(TableDepth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .busy_i   (clearing),
    .size_i   (size_q),
    .push     (push),
    .full     (full),
    .bucket_i (bucket_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .item_o   (f_item),
    .home_o   (f_home)
  );

  hbm_queue #(
    .DataW(QDataW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_item, f_home}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign b_item = q_out[QDataW-1:SlotW];
  assign b_home = q_out[SlotW-1:0];

  hbm_back #(
    .TableDepth(TableDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .size_i    (size_q),
    .busy_o    (clearing),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .item_i    (b_item),
    .home_i    (b_home),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule
